// ===== src/bdpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdpt_pkg;

    localparam int SWITCH_COUNT = 3;
    localparam int COUNT_BITS   = 16;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [SWITCH_COUNT-1:0] sw_vec_t;
    typedef logic [COUNT_BITS-1:0]   count_t;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHORT_PRESS = 2'd0,
        CFG_LONG_PRESS  = 2'd1,
        CFG_RELEASE     = 2'd2
    } cfg_idx_t;

    localparam logic [CFG_BITS-1:0] SHORT_PRESS_RESET = 16'd100;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET  = 16'd3000;
    localparam logic [CFG_BITS-1:0] RELEASE_RESET     = 16'd20;

    // Shared press/release thresholds
    typedef struct packed {
        count_t short_press_ticks;
        count_t long_press_ticks;
        count_t release_ticks;
    } thresh_t;

    // Per-switch toggle flag status: current and post-update values
    typedef struct packed {
        logic short_now;
        logic long_now;
        logic short_next;
        logic long_next;
    } flag_stat_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

`default_nettype wire

// ===== src/bdpt_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdpt_filter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire bdpt_pkg::sw_vec_t raw,
    output bdpt_pkg::sw_vec_t      level,
    output bdpt_pkg::sw_vec_t      level_next
);
    import bdpt_pkg::*;

    sw_vec_t raw_prev_reg;
    sw_vec_t level_reg;
    sw_vec_t edge_bits;

    // Take the raw level only where it matches the previous read
    always_comb
    begin
        edge_bits  = raw ^ raw_prev_reg;
        level_next = (level_reg & edge_bits) | (raw & ~edge_bits);
    end

    assign level = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= '0;
            level_reg    <= '0;
        end
        else if (advance)
        begin
            raw_prev_reg <= raw;
            level_reg    <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bdpt_judge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdpt_judge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              pressed,
    input  wire bdpt_pkg::thresh_t  thresh,
    output bdpt_pkg::flag_stat_t    stat
);
    import bdpt_pkg::*;

    count_t on_reg;
    count_t on_next;
    count_t off_reg;
    count_t off_next;
    logic   short_reg;
    logic   long_reg;
    logic   released;
    logic   is_long;
    logic   is_short;

    always_comb
    begin
        if (!pressed)
        begin
            off_next = (off_reg == COUNT_MAX) ? COUNT_MAX : off_reg + count_t'(1);
            released = (off_next >= thresh.release_ticks);
            on_next  = released ? '0 : on_reg;
        end
        else
        begin
            on_next  = (on_reg == COUNT_MAX) ? COUNT_MAX : on_reg + count_t'(1);
            off_next = '0;
            released = (thresh.release_ticks == '0);
        end

        // Judge on the ON count held before this tick; long wins over short
        is_long  = (on_reg >= thresh.long_press_ticks);
        is_short = !is_long && (on_reg >= thresh.short_press_ticks);

        stat.short_now  = short_reg;
        stat.long_now   = long_reg;
        stat.short_next = short_reg ^ (is_short && released);
        stat.long_next  = long_reg ^ (is_long && released);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= '0;
            off_reg   <= '0;
            short_reg <= 1'b0;
            long_reg  <= 1'b0;
        end
        else if (advance)
        begin
            on_reg    <= on_next;
            off_reg   <= off_next;
            short_reg <= stat.short_next;
            long_reg  <= stat.long_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/button_debounce_press_toggle.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounce for a bank of push switches with short- and long-press toggle flags.
// Input channel (s_axis_*): one item per sample tick, raw switch levels in
// tdata[2:0] (bit0 right, bit1 center, bit2 left, 1 = pressed).
// Output channel (m_axis_*): one item per input item, carrying the filtered
// levels and the short- and long-press toggle flags after that tick.
// Configuration: cfg_wr_en / cfg_index / cfg_data write the short-press,
// long-press and release thresholds (in ticks); write only while idle.
// Path: an accepted item passes the input register, then the result register,
// to the output. Throughput: one item per cycle while m_axis_tready stays high;
// the switch state update is a single pass of counter and compare logic.
// Reset: all counters, flags and filter state clear, thresholds return to
// 100 / 3000 / 20 ticks, both channels come up empty.
// Stall: while the receiver holds m_axis_tready low the result holds, one
// more item is taken into the input register, and then s_axis_tready drops
// until the result drains. Nothing is lost or repeated.
module button_debounce_press_toggle (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [2:0] raw_switches, [7:3] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [2:0] filtered_level,
                                             // [5:3] short_toggles,
                                             // [8:6] long_toggles, [15:9] zero
    input  wire logic        cfg_wr_en,
    input  wire logic [bdpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [bdpt_pkg::CFG_BITS-1:0]     cfg_data
);
    import bdpt_pkg::*;

    localparam int OUT_BITS = 3 * SWITCH_COUNT;

    thresh_t       thresh_reg;
    logic          in_valid_reg;
    sw_vec_t       in_raw_reg;
    logic          out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;
    logic          fire;
    sw_vec_t       level;
    sw_vec_t       level_next;
    flag_stat_t    stat [SWITCH_COUNT];
    sw_vec_t       short_next;
    sw_vec_t       long_next;
    sw_vec_t       short_now;
    sw_vec_t       long_now;

    // Advance the switch state whenever the input register holds an item and
    // the result register is free or draining this cycle.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    // Threshold registers; an index beyond the map is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_press_ticks <= SHORT_PRESS_RESET;
            thresh_reg.long_press_ticks  <= LONG_PRESS_RESET;
            thresh_reg.release_ticks     <= RELEASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SHORT_PRESS: thresh_reg.short_press_ticks <= cfg_data;
                CFG_LONG_PRESS:  thresh_reg.long_press_ticks  <= cfg_data;
                CFG_RELEASE:     thresh_reg.release_ticks     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_raw_reg <= s_axis_tdata[SWITCH_COUNT-1:0];
        end
    end

    bdpt_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (fire),
        .raw        (in_raw_reg),
        .level      (level),
        .level_next (level_next)
    );

    // One press judge per switch, all sharing the thresholds
    for (genvar i = 0; i < SWITCH_COUNT; i++)
    begin : g_judge
        bdpt_judge u_judge (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (fire),
            .pressed (level_next[i]),
            .thresh  (thresh_reg),
            .stat    (stat[i])
        );

        assign short_next[i] = stat[i].short_next;
        assign long_next[i]  = stat[i].long_next;
        assign short_now[i]  = stat[i].short_now;
        assign long_now[i]   = stat[i].long_now;
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {long_next, short_next, level_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - OUT_BITS){1'b0}}, out_data_reg};

`ifndef NO_ASSERTIONS
    // A completed item always lands in the result register
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("result register did not take a completed item");

    // The input register always has room when empty
    a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while input register is empty");

    // Filter state only moves when an item is processed
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(level))
        else $error("filtered level changed without an item");

    // One release never toggles both the short and the long flag of a switch
    a_one_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (((short_next ^ short_now) & (long_next ^ long_now)) == '0))
        else $error("short and long flag toggled together");
`endif

endmodule

`default_nettype wire
